// ===== design/pcjq_pkg.sv =====
// Package for the priority class job queue: sizes, codes and payload types.
package pcjq_pkg;

    // Sizes
    localparam int NUM_CLASSES   = 4;
    localparam int QUEUE_DEPTH   = 16;
    localparam int HANDLE_BITS   = 16;
    localparam int MAX_FALLBACKS = 3;
    localparam int CLS_W         = $clog2(NUM_CLASSES);
    localparam int PTR_W         = $clog2(QUEUE_DEPTH);
    localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W        = CLS_W + PTR_W;
    localparam int STORE_DEPTH   = 1 << ADDR_W;

    // Operation codes
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // Status codes
    localparam logic [2:0] ST_PUSHED  = 3'd0;
    localparam logic [2:0] ST_LOCKED  = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_POPPED  = 3'd3;
    localparam logic [2:0] ST_PRESENT = 3'd4;
    localparam logic [2:0] ST_EMPTY   = 3'd5;

    // Configuration register indexes
    localparam logic REG_PUSH_LOCKED = 1'b0;

    // Command payload
    typedef struct packed {
        logic [1:0]  operation;
        logic [1:0]  priority_req;
        logic [15:0] job_handle;
        logic [1:0]  fallback_count;
        logic [1:0]  fallback_first;
        logic [1:0]  fallback_second;
        logic [1:0]  fallback_third;
    } cmd_t;

    // Result payload
    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] job_handle_out;
        logic [1:0]  served_priority;
    } result_t;

endpackage

// ===== design/pcjq_ram.sv =====
// Generic single-port-write, registered-read RAM.
module pcjq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/priority_class_job_queue.sv =====
// Top level of the priority class job queue.
//
// Usage: a command is transferred at a rising edge with start high and busy
// low. busy is always low: one command can be transferred in every cycle.
// Push appends job_handle to the FIFO of priority_req; pop removes the head
// of the first non-empty class among the preferred class and up to
// fallback_count fallbacks; query runs the same search without removing.
// Each command gives exactly one result, shown on result for one cycle with
// done high, in the cycle right after its transfer. The result timing is
// set by the registered read of the handle store RAM; head, tail and fill
// counts live in flip-flops, so a command can follow the previous one
// directly. The receiver cannot stall: results must be taken.
// Reset empties every class and clears push_locked; the handle store keeps
// its contents, but only occupied entries ever reach the result.
// push_locked is written over the APB port at byte address 0.
module priority_class_job_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready,
    input  logic            start,
    output logic            busy,
    input  pcjq_pkg::cmd_t  cmd,
    output logic            done,
    output pcjq_pkg::result_t result
);
    import pcjq_pkg::*;

    logic                   push_locked_reg;
    logic [PTR_W-1:0]       head_reg [NUM_CLASSES];
    logic [PTR_W-1:0]       tail_reg [NUM_CLASSES];
    logic [CNT_W-1:0]       fill_reg [NUM_CLASSES];
    logic [PTR_W-1:0]       head_next [NUM_CLASSES];
    logic [PTR_W-1:0]       tail_next [NUM_CLASSES];
    logic [CNT_W-1:0]       fill_next [NUM_CLASSES];
    logic                   done_reg;
    logic [2:0]             status_reg, status_next;
    logic [CLS_W-1:0]       served_reg, served_next;
    logic                   pop_reg, pop_next;

    logic                   accept;
    logic                   cfg_write;
    logic [1:0]             cand [4];
    logic                   found;
    logic [CLS_W-1:0]       found_cls;
    logic [CLS_W-1:0]       push_cls;
    logic                   push_cls_ok;
    logic                   push_ok;
    logic                   pop_ok;
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [HANDLE_BITS-1:0] ram_rdata;

    // APB side
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_PUSH_LOCKED) ? {31'd0, push_locked_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push_locked_reg <= 1'b0;
        end
        else if (cfg_write && paddr[2] == REG_PUSH_LOCKED)
        begin
            push_locked_reg <= pwdata[0];
        end
    end

    // Command transfer: the queue takes one command every cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Candidate search over preferred class and fallbacks
    assign cand[0] = cmd.priority_req;
    assign cand[1] = cmd.fallback_first;
    assign cand[2] = cmd.fallback_second;
    assign cand[3] = cmd.fallback_third;

    always_comb
    begin
        found     = 1'b0;
        found_cls = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (!found && i <= int'(cmd.fallback_count) && i <= MAX_FALLBACKS &&
                int'(cand[i]) < NUM_CLASSES &&
                fill_reg[cand[i][CLS_W-1:0]] != '0)
            begin
                found     = 1'b1;
                found_cls = cand[i][CLS_W-1:0];
            end
        end
    end

    // Push checks
    assign push_cls    = cmd.priority_req[CLS_W-1:0];
    assign push_cls_ok = int'(cmd.priority_req) < NUM_CLASSES;
    assign push_ok     = accept && cmd.operation == OP_PUSH && !push_locked_reg &&
                         push_cls_ok && int'(fill_reg[push_cls]) < QUEUE_DEPTH;
    assign pop_ok      = accept && cmd.operation == OP_POP && found;

    // Handle store access
    assign ram_we    = push_ok;
    assign ram_waddr = {push_cls, tail_reg[push_cls]};
    assign ram_raddr = {found_cls, head_reg[found_cls]};

    pcjq_ram #(
        .WIDTH (HANDLE_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cmd.job_handle[HANDLE_BITS-1:0]),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Pointer and count updates, result fields
    always_comb
    begin
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            head_next[c] = head_reg[c];
            tail_next[c] = tail_reg[c];
            fill_next[c] = fill_reg[c];
        end
        if (push_ok)
        begin
            tail_next[push_cls] = (int'(tail_reg[push_cls]) == QUEUE_DEPTH - 1) ?
                                  '0 : tail_reg[push_cls] + 1'b1;
            fill_next[push_cls] = fill_reg[push_cls] + 1'b1;
        end
        if (pop_ok)
        begin
            head_next[found_cls] = (int'(head_reg[found_cls]) == QUEUE_DEPTH - 1) ?
                                   '0 : head_reg[found_cls] + 1'b1;
            fill_next[found_cls] = fill_reg[found_cls] - 1'b1;
        end

        status_next = ST_EMPTY;
        served_next = '0;
        pop_next    = 1'b0;
        case (cmd.operation)
            OP_PUSH:
            begin
                served_next = push_cls;
                if (push_locked_reg)
                begin
                    status_next = ST_LOCKED;
                end
                else if (push_ok)
                begin
                    status_next = ST_PUSHED;
                end
                else
                begin
                    status_next = ST_FULL;
                end
            end
            OP_POP:
            begin
                if (found)
                begin
                    status_next = ST_POPPED;
                    served_next = found_cls;
                    pop_next    = 1'b1;
                end
            end
            OP_QUERY:
            begin
                if (found)
                begin
                    status_next = ST_PRESENT;
                    served_next = found_cls;
                end
            end
            default:
            begin
                status_next = ST_EMPTY;
            end
        endcase
    end

    // Queue bookkeeping registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                head_reg[c] <= '0;
                tail_reg[c] <= '0;
                fill_reg[c] <= '0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                head_reg[c] <= head_next[c];
                tail_reg[c] <= tail_next[c];
                fill_reg[c] <= fill_next[c];
            end
            done_reg <= accept;
        end
    end

    // Result payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            served_reg <= served_next;
            pop_reg    <= pop_next;
        end
    end

    // Result transfer
    assign done                   = done_reg;
    assign result.status          = status_reg;
    assign result.job_handle_out  = pop_reg ? 16'(ram_rdata) : 16'd0;
    assign result.served_priority = 2'(served_reg);

endmodule

// ===== design/pcjq_checker.sv =====
// Port-level checker for the priority class job queue, with its bind.
module pcjq_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input pcjq_pkg::result_t result
);
    import pcjq_pkg::*;

    // Every transferred command gives a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("command transfer without result");

    // No result without a command in the previous cycle
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("result without command");

    // Only a pop carries a handle
    a_handle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_POPPED) |-> result.job_handle_out == 16'd0)
        else $error("handle on a result that is not a pop");

    // Empty result reports class zero, and status stays in range
    a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status <= ST_EMPTY &&
                  (result.status != ST_EMPTY || result.served_priority == 2'd0)))
        else $error("bad status or class on result");

endmodule

bind priority_class_job_queue pcjq_checker u_pcjq_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// ===== tb/priority_class_job_queue_tb.sv =====
// Self-checking testbench for the priority class job queue: directed and random commands.
module priority_class_job_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pcjq_pkg::*;

    // Opcode the block leaves unused, sent as noise
    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam logic [2:0] LOCK_ADDR   = 3'(4 * REG_PUSH_LOCKED);
    localparam int         STALL_LIMIT = 2000;
    localparam int         NUM_PHASES  = 8;
    localparam int         PHASE_ITEMS = 250;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start   = 1'b0;
    logic        busy;
    cmd_t        cmd     = '0;
    logic        done;
    result_t     result;

    // Mirror of the block's state for prediction
    logic [HANDLE_BITS-1:0] class_store [NUM_CLASSES][QUEUE_DEPTH];
    logic [PTR_W-1:0]       class_head  [NUM_CLASSES] = '{default: '0};
    logic [PTR_W-1:0]       class_tail  [NUM_CLASSES] = '{default: '0};
    logic [CNT_W-1:0]       class_fill  [NUM_CLASSES] = '{default: '0};
    logic                   lock_mirror = 1'b0;

    result_t expected_job_results [$];
    int      mismatches  = 0;
    int      quiet_cycles = 0;
    int      status_tally [6] = '{default: 0};
    int      cmds_sent   = 0;

    priority_class_job_queue dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .done    (done),
        .result  (result)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [PTR_W-1:0] ring_next(logic [PTR_W-1:0] idx);
        return (int'(idx) == QUEUE_DEPTH - 1) ? '0 : idx + 1'b1;
    endfunction

    // Predicted result of one command; updates the mirrored queues
    function automatic result_t predict_job_result(cmd_t c);
        result_t     r;
        logic [1:0]  cand [4];
        int          n_cand;
        bit          found;
        logic [1:0]  cls;
        r.status          = ST_EMPTY;
        r.job_handle_out  = '0;
        r.served_priority = '0;
        case (c.operation)
            OP_PUSH:
            begin
                cls = c.priority_req;
                r.served_priority = cls;
                if (lock_mirror)
                    r.status = ST_LOCKED;
                else if (int'(cls) >= NUM_CLASSES || int'(class_fill[cls]) >= QUEUE_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    class_store[cls][class_tail[cls]] = c.job_handle[HANDLE_BITS-1:0];
                    class_tail[cls] = ring_next(class_tail[cls]);
                    class_fill[cls] = class_fill[cls] + 1'b1;
                    r.status = ST_PUSHED;
                end
            end
            OP_POP, OP_QUERY:
            begin
                cand[0] = c.priority_req;
                cand[1] = c.fallback_first;
                cand[2] = c.fallback_second;
                cand[3] = c.fallback_third;
                n_cand = 1 + ((int'(c.fallback_count) > MAX_FALLBACKS) ?
                              MAX_FALLBACKS : int'(c.fallback_count));
                found = 1'b0;
                for (int i = 0; i < n_cand; i++)
                begin
                    cls = cand[i];
                    if (!found && int'(cls) < NUM_CLASSES && class_fill[cls] != 0)
                    begin
                        found = 1'b1;
                        r.served_priority = cls;
                        if (c.operation == OP_POP)
                        begin
                            r.job_handle_out = class_store[cls][class_head[cls]];
                            class_head[cls]  = ring_next(class_head[cls]);
                            class_fill[cls]  = class_fill[cls] - 1'b1;
                            r.status = ST_POPPED;
                        end
                        else
                            r.status = ST_PRESENT;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic cmd_t make_cmd(logic [1:0] op, logic [1:0] pri, logic [15:0] handle,
                                      logic [1:0] nfall, logic [1:0] f1, logic [1:0] f2,
                                      logic [1:0] f3);
        cmd_t c;
        c.operation       = op;
        c.priority_req    = pri;
        c.job_handle      = handle;
        c.fallback_count  = nfall;
        c.fallback_first  = f1;
        c.fallback_second = f2;
        c.fallback_third  = f3;
        return c;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap(bit idle_on);
        int r;
        r = $urandom_range(99);
        if (!idle_on || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Drive one command, wait for its transfer, then idle for gap cycles
    task automatic send_cmd(cmd_t c, int gap);
        result_t predicted;
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = predict_job_result(c);
        expected_job_results.insert(expected_job_results.size(), predicted);
        status_tally[predicted.status]++;
        cmds_sent++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        while (expected_job_results.size() != 0)
            @(posedge clk);
    endtask

    // Write push_locked on an idle block, then read it back
    task automatic write_push_lock(logic val);
        wait_for_results();
        repeat (2) @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= LOCK_ADDR;
        pwdata  <= {31'b0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        lock_mirror = val;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== {31'b0, val})
        begin
            $display("%0t ns: push_locked readback mismatch, expected %0h, actual %0h",
                     $time, {31'b0, val}, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Pop, query and the unused opcode on an empty queue
    task automatic test_empty_queue();
        send_cmd(make_cmd(OP_POP, 2'd0, 16'h0000, 2'd0, 2'd0, 2'd0, 2'd0), pick_gap(1));
        send_cmd(make_cmd(OP_QUERY, 2'd1, 16'hFFFF, 2'd3, 2'd2, 2'd3, 2'd0), pick_gap(1));
        send_cmd(make_cmd(OP_POP, 2'd3, 16'h1234, 2'd3, 2'd1, 2'd2, 2'd0), 0);
        send_cmd(make_cmd(OP_UNUSED, 2'd3, 16'hFFFF, 2'd3, 2'd3, 2'd3, 2'd3), 0);
    endtask

    // Fallback order, repeated classes, fallback count limit, query checks fallbacks
    task automatic test_fallback_search();
        send_cmd(make_cmd(OP_PUSH, 2'd1, 16'h0000, 2'd0, 2'd0, 2'd0, 2'd0), 0);
        send_cmd(make_cmd(OP_PUSH, 2'd2, 16'hFFFF, 2'd3, 2'd3, 2'd3, 2'd3), pick_gap(1));
        send_cmd(make_cmd(OP_QUERY, 2'd0, 16'h0000, 2'd1, 2'd1, 2'd0, 2'd0), 0);
        send_cmd(make_cmd(OP_QUERY, 2'd0, 16'h0000, 2'd3, 2'd0, 2'd0, 2'd2), 0);
        send_cmd(make_cmd(OP_POP, 2'd3, 16'h0000, 2'd2, 2'd3, 2'd3, 2'd2), pick_gap(1));
        send_cmd(make_cmd(OP_POP, 2'd0, 16'h0000, 2'd3, 2'd3, 2'd0, 2'd2), 0);
        send_cmd(make_cmd(OP_POP, 2'd1, 16'h0000, 2'd0, 2'd2, 2'd2, 2'd2), 0);
    endtask

    // Fill one class to the top, then one more push is refused
    task automatic test_full_class();
        for (int i = 0; i <= QUEUE_DEPTH; i++)
            send_cmd(make_cmd(OP_PUSH, 2'd3, 16'(i * 16'h1111), 2'd0, 2'd0, 2'd0, 2'd0),
                     pick_gap(i[0]));
    endtask

    // Locked pushes are refused even on a full class
    task automatic test_push_lock();
        write_push_lock(1'b1);
        send_cmd(make_cmd(OP_PUSH, 2'd3, 16'hA5A5, 2'd0, 2'd0, 2'd0, 2'd0), 0);
        send_cmd(make_cmd(OP_PUSH, 2'd0, 16'h5A5A, 2'd0, 2'd0, 2'd0, 2'd0), 0);
        write_push_lock(1'b0);
    endtask

    function automatic cmd_t random_cmd(int push_pct);
        cmd_t c;
        int   r;
        c = make_cmd(OP_POP, 2'($urandom_range(3)), 16'($urandom), 2'($urandom_range(3)),
                     2'($urandom_range(3)), 2'($urandom_range(3)), 2'($urandom_range(3)));
        r = $urandom_range(99);
        if (r < 3)
            c.operation = OP_UNUSED;
        else if (r < 3 + push_pct)
            c.operation = OP_PUSH;
        else if ($urandom_range(99) < 35)
            c.operation = OP_QUERY;
        if ($urandom_range(7) == 0)
            c.job_handle = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        return c;
    endfunction

    // Random phases with varying operation mix, lock setting and idling
    task automatic test_random_phases();
        int push_mix [NUM_PHASES] = '{60, 30, 75, 20, 50, 90, 15, 45};
        bit lock_set [NUM_PHASES] = '{0, 0, 0, 1, 0, 0, 1, 0};
        bit idle_on;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_push_lock(lock_set[p]);
            idle_on = (p % 3) != 2;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // let all outstanding results arrive once per phase
                if (i == PHASE_ITEMS / 2)
                    wait_for_results();
                send_cmd(random_cmd(push_mix[p]), pick_gap(idle_on));
            end
        end
    endtask

    task automatic check_field(string what, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    // Compare each result with the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (expected_job_results.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, actual %0h",
                         $time, result);
                mismatches++;
            end
            else
            begin
                want = expected_job_results.pop_front();
                check_field("status", 16'(want.status), 16'(result.status));
                check_field("job_handle_out", want.job_handle_out, result.job_handle_out);
                check_field("served_priority", 16'(want.served_priority),
                            16'(result.served_priority));
            end
        end
    end

    // Watchdog: cycles without any transfer
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t ns: watchdog, no transfer for %0d cycles", $time, quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_fallback_search();
        test_full_class();
        test_push_lock();
        test_random_phases();

        start <= 1'b0;
        for (int k = 0; k < 50 && expected_job_results.size() != 0; k++)
            @(posedge clk);
        repeat (3) @(posedge clk);
        if (expected_job_results.size() != 0)
        begin
            $display("%0t ns: missing results, expected %0d more, actual 0",
                     $time, expected_job_results.size());
            mismatches += expected_job_results.size();
        end

        $display("Ran %0d commands with push_locked at 0 and 1: %0d pushed, %0d locked, %0d full,",
                 cmds_sent, status_tally[ST_PUSHED], status_tally[ST_LOCKED],
                 status_tally[ST_FULL]);
        $display("  %0d popped, %0d present, %0d empty; %0d mismatches.",
                 status_tally[ST_POPPED], status_tally[ST_PRESENT], status_tally[ST_EMPTY],
                 mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
